// ===== src/mpq_pkg.sv =====
// shared types and codes for the max-key priority queue
// no dependencies; imported by max_key_priority_queue, mpq_checker and tb
package mpq_pkg;

   localparam logic [1:0] MODE_PUSH      = 2'd0;
   localparam logic [1:0] MODE_TAKE_OLD  = 2'd1;
   localparam logic [1:0] MODE_PEEK_MAX  = 2'd2;
   localparam logic [1:0] MODE_TAKE_MAX  = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] item_key;
      logic [31:0]        item_data;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] found_key;
      logic [31:0]        found_data;
      logic [4:0]         fill_count;
   } rsp_type;

endpackage

// ===== src/max_key_priority_queue.sv =====
// max-key priority queue top level: sequencer, entry ring buffer, one key comparator
// depends on mpq_pkg and mpq_ram
//
// Holds up to DEPTH key/data entries in insertion order in a ring buffer ram.
// A request is taken when start is high and busy is low; its one result beat
// shows on rsp_item for exactly one cycle with rsp_valid high and cannot be
// held off, so the receiver must take it then. A push, and any request on an
// empty store or a push on a full one, answers in the cycle after acceptance
// and leaves busy low. Take-oldest reads the oldest entry in S_OLD and answers
// from there. Peek-largest walks the ram with a single signed comparator, one
// entry per cycle from newest to oldest, the newest of equal keys winning.
// Take-largest then moves each entry newer than the chosen one down one slot,
// through the ram's single write port in S_SHIFT.
module max_key_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  mpq_pkg::req_type req_item,
   output logic            rsp_valid,
   output mpq_pkg::rsp_type rsp_item
);
   import mpq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_OLD   = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_SHIFT = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [1:0]         mode_ff, mode_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic signed [31:0] best_key_ff, best_key_in;
   logic [31:0]        best_data_ff, best_data_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [63:0]        wr_data;
   logic [AW-1:0]      rd_addr;
   logic [63:0]        rd_data;

   logic [AW-1:0]      last_idx;
   logic signed [31:0] rd_key;
   logic               take_new;

   // logical slot to ram address, wrapping at DEPTH
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] slot);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, slot};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   mpq_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign last_idx = AW'(count_ff - 1'b1);
   assign rd_key   = rd_data[63:32];
   // first entry seen always wins, later ones only on strictly greater
   assign take_new = (idx_ff == last_idx) || (rd_key > best_key_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      best_key_in  = best_key_ff;
      best_data_in = best_data_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, AW'(count_ff));
      wr_data      = {req_item.item_key, req_item.item_data};
      rd_addr      = phys(head_ff, '0);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_item.mode;
               if (req_item.mode == MODE_PUSH) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CW'(DEPTH)) begin
                     rsp_in = '{STATUS_FULL, '0, '0, 5'(count_ff)};
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     rsp_in   = '{STATUS_OK, req_item.item_key, req_item.item_data,
                                  5'(count_in)};
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{STATUS_EMPTY, '0, '0, 5'(count_ff)};
               end else if (req_item.mode == MODE_TAKE_OLD) begin
                  state_in = S_OLD;
               end else begin
                  rd_addr  = phys(head_ff, last_idx);
                  idx_in   = last_idx;
                  state_in = S_SCAN;
               end
            end
         end

         S_OLD: begin
            head_in      = phys(head_ff, AW'(1));
            count_in     = count_ff - 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in       = '{STATUS_OK, rd_key, rd_data[31:0], 5'(count_in)};
            state_in     = S_IDLE;
         end

         S_SCAN: begin
            if (take_new) begin
               best_key_in  = rd_key;
               best_data_in = rd_data[31:0];
               best_idx_in  = idx_ff;
            end
            if (idx_ff == '0) begin
               if (mode_ff == MODE_PEEK_MAX) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{STATUS_OK, best_key_in, best_data_in, 5'(count_ff)};
                  state_in     = S_IDLE;
               end else if (best_idx_in == last_idx) begin
                  // newest entry removed, nothing to move
                  count_in     = count_ff - 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{STATUS_OK, best_key_in, best_data_in, 5'(count_in)};
                  state_in     = S_IDLE;
               end else begin
                  rd_addr  = phys(head_ff, AW'(best_idx_in + 1'b1));
                  idx_in   = best_idx_in;
                  state_in = S_SHIFT;
               end
            end else begin
               rd_addr = phys(head_ff, AW'(idx_ff - 1'b1));
               idx_in  = AW'(idx_ff - 1'b1);
            end
         end

         S_SHIFT: begin
            // entry idx+1 arrives, lands in slot idx
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, idx_ff);
            wr_data = rd_data;
            if (AW'(idx_ff + 1'b1) == last_idx) begin
               count_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{STATUS_OK, best_key_ff, best_data_ff, 5'(count_in)};
               state_in     = S_IDLE;
            end else begin
               rd_addr = phys(head_ff, AW'(idx_ff + 2'd2));
               idx_in  = AW'(idx_ff + 1'b1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      best_key_ff  <= best_key_in;
      best_data_ff <= best_data_in;
      best_idx_ff  <= best_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== src/mpq_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module mpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/mpq_checker.sv =====
// result checker for the max-key priority queue: tracks accepted requests,
// predicts each response beat and compares it. depends on mpq_pkg
`timescale 1ns / 1ps

module mpq_checker #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  mpq_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  mpq_pkg::rsp_type rsp_item,
   output int               error_count,
   output int               pending_count,
   output int               result_count,
   output int               push_count,
   output int               full_count,
   output int               empty_count,
   output int               max_take_count
);
   import mpq_pkg::*;

   // shadow copy of the store, oldest entry in slot 0
   logic signed [31:0] shadow_key [DEPTH];
   logic [31:0]        shadow_data [DEPTH];
   int                 held;

   rsp_type expected_rsp [$];
   int errors, results, pushes, fulls, empties, max_takes;

   initial begin
      held = 0;
      errors = 0;
      results = 0;
      pushes = 0;
      fulls = 0;
      empties = 0;
      max_takes = 0;
   end

   // applies one request to the shadow store and returns the response it causes
   function automatic rsp_type apply_request(req_type r);
      rsp_type o;
      int      pick;
      int      i;
      o = '0;
      o.status = STATUS_OK;
      if (r.mode == MODE_PUSH) begin
         if (held >= DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            shadow_key[held] = r.item_key;
            shadow_data[held] = r.item_data;
            held++;
            o.found_key = r.item_key;
            o.found_data = r.item_data;
         end
      end else if (held == 0) begin
         o.status = STATUS_EMPTY;
      end else begin
         pick = 0;
         if (r.mode != MODE_TAKE_OLD) begin
            // newest first, strict compare so the newest of equal keys stays
            pick = held - 1;
            for (i = held - 2; i >= 0; i--)
               if (shadow_key[i] > shadow_key[pick]) pick = i;
         end
         o.found_key = shadow_key[pick];
         o.found_data = shadow_data[pick];
         if (r.mode != MODE_PEEK_MAX) begin
            for (i = pick; i < held - 1; i++) begin
               shadow_key[i] = shadow_key[i + 1];
               shadow_data[i] = shadow_data[i + 1];
            end
            held--;
         end
      end
      o.fill_count = 5'(held);
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h",
                     $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      rsp_type new_rsp;
      if (reset) begin
         held = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid) begin
            results++;
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= 40)
                  $display("%0t: unexpected response beat: expected none, got %p",
                           $time, rsp_item);
            end else begin
               exp_rsp = expected_rsp.pop_front();
               check_field("status", 32'(exp_rsp.status), 32'(rsp_item.status));
               check_field("found_key", exp_rsp.found_key, rsp_item.found_key);
               check_field("found_data", exp_rsp.found_data, rsp_item.found_data);
               check_field("fill_count", 32'(exp_rsp.fill_count),
                           32'(rsp_item.fill_count));
            end
         end
         if (start && !busy) begin
            new_rsp = apply_request(req_item);
            expected_rsp.push_back(new_rsp);
            if (req_item.mode == MODE_PUSH && new_rsp.status == STATUS_OK) pushes++;
            if (new_rsp.status == STATUS_FULL) fulls++;
            if (new_rsp.status == STATUS_EMPTY) empties++;
            if (req_item.mode == MODE_TAKE_MAX && new_rsp.status == STATUS_OK)
               max_takes++;
         end
      end
      // counts go out registered so the stimulus side reads them race free
      error_count <= errors;
      pending_count <= expected_rsp.size();
      result_count <= results;
      push_count <= pushes;
      full_count <= fulls;
      empty_count <= empties;
      max_take_count <= max_takes;
   end

endmodule

// ===== dv/tb.sv =====
// testbench top for max_key_priority_queue: clock, reset, request stimulus
// and verdict. depends on mpq_pkg, max_key_priority_queue and mpq_checker
`timescale 1ns / 1ps

module tb;
   import mpq_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_REQS = 850;
   localparam int DRAIN_CYCLES = 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   int error_count, pending_count, result_count;
   int push_count, full_count, empty_count, max_take_count;

   max_key_priority_queue #(.DEPTH(DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   mpq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .result_count   (result_count),
      .push_count     (push_count),
      .full_count     (full_count),
      .empty_count    (empty_count),
      .max_take_count (max_take_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // holds the request until a clock edge takes it
   task automatic issue(input logic [1:0] mode, input logic [31:0] key,
                        input logic [31:0] data);
      req_type r;
      r.mode = mode;
      r.item_key = key;
      r.item_data = data;
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // keys lean toward extremes and a narrow band so ties happen often
   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 6)) - 32'd3;
         3: return 32'($urandom_range(0, 3)) + 32'h7fff_fffc;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_data();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   logic [31:0] fill_keys [DEPTH] = '{
      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
      32'h0000_0005, 32'h0000_0005, 32'h7fff_ffff, 32'h0000_0001,
      32'h8000_0000, 32'h0000_0002, 32'h0000_0003, 32'hffff_fffe,
      32'h7fff_fffe, 32'h0000_0004, 32'h7fff_ffff, 32'h0000_0006
   };

   initial begin
      int          sent;
      int          burst;
      int          push_weight;
      int          waited;
      logic [1:0]  mode;
      start = 1'b0;
      req_item = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store on every removing or looking request
      issue(MODE_TAKE_OLD, $urandom, $urandom);
      issue(MODE_PEEK_MAX, $urandom, $urandom);
      idle(3);
      issue(MODE_TAKE_MAX, $urandom, $urandom);
      // fill to the top with extreme keys and ties, then overflow
      for (int i = 0; i < DEPTH; i++) begin
         issue(MODE_PUSH, fill_keys[i], (i % 2 == 0) ? 32'h0 : 32'hffff_ffff);
         if (i % 5 == 4) idle(2);
      end
      issue(MODE_PUSH, 32'h1234_5678, 32'h8765_4321);
      issue(MODE_PEEK_MAX, $urandom, $urandom);
      issue(MODE_TAKE_MAX, $urandom, $urandom);
      idle(1);
      issue(MODE_TAKE_OLD, $urandom, $urandom);
      issue(MODE_TAKE_MAX, $urandom, $urandom);

      // random bursts; push weight changes every so often to sweep the fill level
      sent = 0;
      push_weight = 50;
      while (sent < RANDOM_REQS) begin
         if (sent % 60 == 0 || $urandom_range(0, 19) == 0)
            case ($urandom_range(0, 2))
               0: push_weight = 15;
               1: push_weight = 50;
               default: push_weight = 85;
            endcase
         burst = $urandom_range(1, 16);
         for (int b = 0; b < burst && sent < RANDOM_REQS; b++) begin
            if ($urandom_range(0, 99) < push_weight) mode = MODE_PUSH;
            else mode = 2'($urandom_range(1, 3));
            issue(mode, pick_key(), pick_data());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
      end
      start <= 1'b0;

      // let every outstanding beat come back
      @(posedge clock);
      waited = 0;
      while (pending_count != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d response beats: %0d pushes, %0d refused on full store,",
               result_count, push_count, full_count);
      $display("  %0d answered on empty store, %0d largest-key removals",
               empty_count, max_take_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         if (pending_count != 0)
            $display("%0t: %0d expected beats never arrived", $time, pending_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/mpq_pkg.sv
src/mpq_ram.sv
src/max_key_priority_queue.sv
dv/mpq_checker.sv
dv/tb.sv
